[rtl/pcbd_pkg.sv]
// Package: shared types and constants for the pulse-count backlight dimmer.
`timescale 1ns / 1ps

package pcbd_pkg;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HALF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 2'd2;

  // Field widths
  localparam int BRIGHT_W = 8;
  localparam int EN_W     = 10;
  localparam int HALF_W   = 8;
  localparam int DUR_W    = 16;

  // Register reset values
  localparam logic [EN_W-1:0]   ENABLE_DELAY_RST = 10'd30;
  localparam logic [HALF_W-1:0] PULSE_HALF_RST   = 8'd1;
  localparam logic [DUR_W-1:0]  SETTLE_RST       = 16'd1000;

  // Rounding: lvl = (2*LEVELS*v + FULL_SCALE) / (2*FULL_SCALE)
  localparam int FULL_SCALE = 255;
  localparam int DIV_CONST  = 2 * FULL_SCALE;

  // A run never exceeds this many segments, so the step count saturates
  localparam int MAX_RESULTS = 32;
  localparam int MAX_STEPS   = (MAX_RESULTS - 2) / 2;
  localparam int CNT_W       = $clog2(MAX_STEPS + 1);

  // Configuration registers as one group
  typedef struct packed {
    logic [EN_W-1:0]   enable_delay_us;
    logic [HALF_W-1:0] pulse_half_us;
    logic [DUR_W-1:0]  settle_us;
  } cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_TGT,
    ST_PLAN,
    ST_OFF0,
    ST_EN,
    ST_LO,
    ST_HI,
    ST_SETTLE
  } state_t;

endpackage

[rtl/pulse_count_backlight_dimmer.sv]
// Top level: configuration registers and stream ports of the pulse-count backlight dimmer.
//
//   channel  dir  tdata fields (low bit up)            tlast / other
//   s_axis   in   brightness[7:0]                        -
//   m_axis   out  pin_level[0], duration_us[16:1], 0     last of the run
//   cfg      in   cfg_we, cfg_index, cfg_data            write only
//
// A request passes an accept state, a rounding loop in the shared subtractor, the
// target and planning states, then one segment per cycle (up to 32) when the
// output register is free.
// The shared subtractor sets the rounding time; downstream stalls hold the sequencer.
// s_tready is high only between runs; the last beat may still wait while it is.
// rst clears the sequencer, the stored level (off) and the registers to defaults.
`timescale 1ns / 1ps

module pulse_count_backlight_dimmer #(
  parameter int LEVELS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // brightness[7:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [23:0]                        m_tdata,   // pin_level, duration_us[16:1], pad
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [pcbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import pcbd_pkg::*;

  cfg_t             cfg;
  logic             pin_level;
  logic [DUR_W-1:0] duration_us;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_delay_us <= ENABLE_DELAY_RST;
      cfg.pulse_half_us   <= PULSE_HALF_RST;
      cfg.settle_us       <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE_DELAY: cfg.enable_delay_us <= cfg_data[EN_W-1:0];
        REG_PULSE_HALF:   cfg.pulse_half_us   <= cfg_data[HALF_W-1:0];
        REG_SETTLE:       cfg.settle_us       <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  pcbd_seq #(.LEVELS(LEVELS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .brightness  (s_tdata[BRIGHT_W-1:0]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .pin_level   (pin_level),
    .duration_us (duration_us),
    .last        (m_tlast)
  );

  // Pack the beat
  assign m_tdata = {7'b0, duration_us, pin_level};

endmodule

[rtl/pcbd_sub.sv]
// Shared subtract / compare unit used by the rounding, target, planning and pulse-count steps of the sequencer.
`timescale 1ns / 1ps

module pcbd_sub #(
  parameter int W = 14
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  logic [W:0] full;

  // borrow set when a < b
  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule

[rtl/pcbd_seq.sv]
// Sequencer: level rounding, step planning and segment emission over one shared unit.
`timescale 1ns / 1ps

module pcbd_seq #(
  parameter int LEVELS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pcbd_pkg::cfg_t                  cfg,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pcbd_pkg::BRIGHT_W-1:0]   brightness,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic                            pin_level,
  output logic [pcbd_pkg::DUR_W-1:0]      duration_us,
  output logic                            last
);

  import pcbd_pkg::*;

  localparam int LW   = $clog2(LEVELS + 2);
  localparam int OFF  = LEVELS + 1;
  localparam int NUMW = $clog2(2 * LEVELS * FULL_SCALE + FULL_SCALE + 1);
  localparam int AW   = (NUMW > LW + 1) ? NUMW : LW + 1;
  localparam int SW   = (LW + 1 > CNT_W) ? LW + 1 : CNT_W;

  state_t state, state_next;

  logic [NUMW-1:0]  rem, rem_next;
  logic [LW-1:0]    quo, quo_next;
  logic             nz, nz_next;
  logic [LW-1:0]    target, target_next;
  logic [LW-1:0]    cur, cur_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             settle_pin, settle_pin_next;

  logic             m_tvalid_next;
  logic             pin_level_next;
  logic [DUR_W-1:0] duration_us_next;
  logic             last_next;

  logic [AW-1:0]    alu_a, alu_b, alu_diff;
  logic             alu_borrow;
  logic [LW-1:0]    lvl;
  logic [SW-1:0]    steps_raw;
  logic [CNT_W-1:0] steps;
  logic             out_free;

  pcbd_sub #(.W(AW)) u_sub (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // Rounded level; a nonzero request never lands on zero
  assign lvl = (quo == '0 && nz) ? LW'(1) : quo;

  // Step count from the planning subtraction, wrapped and saturated
  assign steps_raw = alu_borrow ? SW'(alu_diff[SW-1:0] + SW'(LEVELS)) : alu_diff[SW-1:0];
  assign steps     = (steps_raw > SW'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : steps_raw[CNT_W-1:0];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      ST_DIV: begin
        alu_a = AW'(rem);
        alu_b = AW'(DIV_CONST);
      end
      ST_TGT: begin
        alu_a = AW'(OFF);
        alu_b = AW'(lvl);
      end
      ST_PLAN: begin
        alu_a = AW'(target);
        alu_b = AW'(cur);
      end
      ST_HI: begin
        alu_a = AW'(cnt);
        alu_b = AW'(1);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // Next state and datapath updates
  always_comb begin
    state_next       = state;
    rem_next         = rem;
    quo_next         = quo;
    nz_next          = nz;
    target_next      = target;
    cur_next         = cur;
    cnt_next         = cnt;
    settle_pin_next  = settle_pin;
    m_tvalid_next    = m_tvalid && !m_tready;
    pin_level_next   = pin_level;
    duration_us_next = duration_us;
    last_next        = last;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          rem_next   = NUMW'(brightness) * NUMW'(2 * LEVELS) + NUMW'(FULL_SCALE);
          quo_next   = '0;
          nz_next    = (brightness != '0);
          state_next = ST_DIV;
        end
      end
      // one subtraction of the divisor per cycle
      ST_DIV: begin
        if (!alu_borrow) begin
          rem_next = alu_diff[NUMW-1:0];
          quo_next = quo + LW'(1);
        end else begin
          state_next = ST_TGT;
        end
      end
      ST_TGT: begin
        target_next = alu_diff[LW-1:0];
        state_next  = ST_PLAN;
      end
      ST_PLAN: begin
        cnt_next = steps;
        cur_next = target;
        if (target == cur) begin
          state_next = ST_IDLE;
        end else if (target == LW'(OFF)) begin
          settle_pin_next = 1'b0;
          state_next      = ST_OFF0;
        end else begin
          settle_pin_next = 1'b1;
          if (cur == LW'(OFF)) begin
            state_next = ST_EN;
          end else if (steps != '0) begin
            state_next = ST_LO;
          end else begin
            state_next = ST_SETTLE;
          end
        end
      end
      ST_OFF0: begin
        if (out_free) begin
          m_tvalid_next    = 1'b1;
          pin_level_next   = 1'b0;
          duration_us_next = '0;
          last_next        = 1'b0;
          state_next       = ST_SETTLE;
        end
      end
      ST_EN: begin
        if (out_free) begin
          m_tvalid_next    = 1'b1;
          pin_level_next   = 1'b1;
          duration_us_next = DUR_W'(cfg.enable_delay_us);
          last_next        = 1'b0;
          state_next       = (cnt != '0) ? ST_LO : ST_SETTLE;
        end
      end
      ST_LO: begin
        if (out_free) begin
          m_tvalid_next    = 1'b1;
          pin_level_next   = 1'b0;
          duration_us_next = DUR_W'(cfg.pulse_half_us);
          last_next        = 1'b0;
          state_next       = ST_HI;
        end
      end
      ST_HI: begin
        if (out_free) begin
          m_tvalid_next    = 1'b1;
          pin_level_next   = 1'b1;
          duration_us_next = DUR_W'(cfg.pulse_half_us);
          last_next        = 1'b0;
          cnt_next         = alu_diff[CNT_W-1:0];
          state_next       = (cnt == CNT_W'(1)) ? ST_SETTLE : ST_LO;
        end
      end
      ST_SETTLE: begin
        if (out_free) begin
          m_tvalid_next    = 1'b1;
          pin_level_next   = settle_pin;
          duration_us_next = cfg.settle_us;
          last_next        = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= LW'(OFF);
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    rem         <= rem_next;
    quo         <= quo_next;
    nz          <= nz_next;
    target      <= target_next;
    cnt         <= cnt_next;
    settle_pin  <= settle_pin_next;
    pin_level   <= pin_level_next;
    duration_us <= duration_us_next;
    last        <= last_next;
  end

  // Stored level is always a real level or off
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    (cur != '0) && (cur <= LW'(OFF)))
    else $error("current level out of range");

  // A high half pulse is only sent with steps left
  a_hi_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HI) |-> (cnt != '0))
    else $error("pulse pair with zero step count");

  // The quotient never passes the level count
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (quo <= LW'(LEVELS)))
    else $error("rounding quotient too large");

  // A request is taken and work starts at once
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_DIV) && !s_tready)
    else $error("sequencer did not start on accepted request");

endmodule

[sim/tb_top.sv]
// Testbench for the pulse-count backlight dimmer: directed table, then random phases against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import pcbd_pkg::*;

  localparam int LEVELS         = 16;
  localparam int OFF_LEVEL      = LEVELS + 1;
  localparam int QUIET_CYCLES   = 80;    // idle wait that covers a request with no result
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AFTER  = 600;   // beats seen before the long receiver hold
  localparam int RAND_PHASES    = 5;
  localparam int PHASE_ITEMS    = 100;
  localparam int REPORT_MAX     = 10;
  // Index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One pin segment: level, hold time, end-of-run mark
  typedef struct packed {
    logic             pin;
    logic [DUR_W-1:0] dur;
    logic             last;
  } seg_t;

  // Directed table row: a register write or a request, optionally with typed results
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  typed;
    logic [1:0]            n_typed;
    seg_t                  s0;
    seg_t                  s1;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BRIGHT_W-1:0]   s_tdata;    // brightness[7:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;    // pin_level, duration_us[16:1], pad
  logic                  m_tlast;    // last segment of the run
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: driver level and register copies
  logic [4:0]        level_now;
  logic [EN_W-1:0]   en_delay;
  logic [HALF_W-1:0] half_us;
  logic [DUR_W-1:0]  settle_hold;
  seg_t              run_segs[$];   // segments of the latest predicted run
  seg_t              segs_due[$];   // segments still to arrive from the block

  logic calm;
  logic held_off;
  int   beats_seen;
  int   faults;
  int   stall_cycles;

  pulse_count_backlight_dimmer #(.LEVELS(LEVELS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic seg_t mk_seg(input logic pin, input logic [DUR_W-1:0] dur,
                                  input logic last);
    seg_t s;
    s.pin  = pin;
    s.dur  = dur;
    s.last = last;
    return s;
  endfunction

  // Round the request to a driver level and plan the pin waveform to reach it
  function automatic void plan_pin_run(input logic [BRIGHT_W-1:0] b);
    int lvl;
    int target;
    int cur;
    int steps;
    run_segs.delete();
    cur = int'(level_now);
    lvl = (2 * LEVELS * int'(b) + FULL_SCALE) / (2 * FULL_SCALE);
    if (lvl == 0 && b != 0) lvl = 1;
    target = OFF_LEVEL - lvl;
    if (target == cur) return;
    // switching off: drop the pin, then hold
    if (target == OFF_LEVEL) begin
      run_segs.push_back(mk_seg(1'b0, '0, 1'b0));
      run_segs.push_back(mk_seg(1'b0, settle_hold, 1'b1));
      level_now = target[4:0];
      return;
    end
    // chip steps one level dimmer per pulse and wraps to brightest
    if (target > cur) steps = target - cur;
    else steps = target + LEVELS - cur;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    if (cur == OFF_LEVEL) run_segs.push_back(mk_seg(1'b1, DUR_W'(en_delay), 1'b0));
    repeat (steps) begin
      run_segs.push_back(mk_seg(1'b0, DUR_W'(half_us), 1'b0));
      run_segs.push_back(mk_seg(1'b1, DUR_W'(half_us), 1'b0));
    end
    run_segs.push_back(mk_seg(1'b1, settle_hold, 1'b1));
    level_now = target[4:0];
  endfunction

  function automatic row_t req_row(input logic [BRIGHT_W-1:0] b);
    row_t r;
    r = '0;
    r.val = CFG_DATA_W'(b);
    return r;
  endfunction

  function automatic row_t typed_row(input logic [BRIGHT_W-1:0] b, input logic [1:0] n,
                                     input seg_t s0, input seg_t s1);
    row_t r;
    r = req_row(b);
    r.typed = 1'b1;
    r.n_typed = n;
    r.s0 = s0;
    r.s1 = s1;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Register value: random half the time, else an extreme (upper bits exercise masking)
  function automatic logic [CFG_DATA_W-1:0] cfg_pick();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [BRIGHT_W-1:0] brightness_pick();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return BRIGHT_W'($urandom_range(255));
    endcase
  endfunction

  // Drain the block: all segments in, then long enough for a request with no result
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (segs_due.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ENABLE_DELAY: en_delay    = val[EN_W-1:0];
      REG_PULSE_HALF:   half_us     = val[HALF_W-1:0];
      REG_SETTLE:       settle_hold = val[DUR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one brightness beat; called and returns at a falling edge
  task automatic send_request(input logic [BRIGHT_W-1:0] b, input logic use_typed,
                              input logic [1:0] n, input seg_t s0, input seg_t s1);
    if (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    plan_pin_run(b);
    if (use_typed) begin
      if (n > 0) segs_due.push_back(s0);
      if (n > 1) segs_due.push_back(s1);
    end else begin
      foreach (run_segs[i]) segs_due.push_back(run_segs[i]);
    end
    @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold while the sender keeps offering
  initial begin
    m_tready = 1'b0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && beats_seen >= HOLDOFF_AFTER && s_tvalid) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // Output check against the oldest segment due
  always @(posedge clk) begin : check_beat
    seg_t due;
    logic missing;
    if (!rst && m_tvalid && m_tready) begin
      beats_seen = beats_seen + 1;
      missing = (segs_due.size() == 0);
      due = missing ? '0 : segs_due.pop_front();
      if (missing || m_tdata[0] !== due.pin || m_tdata[DUR_W:1] !== due.dur ||
          m_tdata[23:DUR_W+1] !== '0 || m_tlast !== due.last) begin
        faults = faults + 1;
        if (faults <= REPORT_MAX)
          $display("%0t: segment mismatch%s: exp pin %0d dur %0d last %0d, got pin %0d dur %0d last %0d pad %0h",
                   $realtime, missing ? " (none due)" : "", due.pin, due.dur, due.last,
                   m_tdata[0], m_tdata[DUR_W:1], m_tlast, m_tdata[23:DUR_W+1]);
      end
    end
  end

  // Watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus
  initial begin : stimulus
    row_t dir_tbl[$];
    int   p;
    int   k;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    beats_seen = 0;
    faults     = 0;
    stall_cycles = 0;
    level_now   = 5'(OFF_LEVEL);
    en_delay    = ENABLE_DELAY_RST;
    half_us     = PULSE_HALF_RST;
    settle_hold = SETTLE_RST;

    // directed: defaults, level extremes, rounding edges, register extremes
    dir_tbl.push_back(typed_row(8'd0, 2'd0, '0, '0));              // already off
    dir_tbl.push_back(typed_row(8'd255, 2'd2, mk_seg(1'b1, 16'd30, 1'b0),
                                mk_seg(1'b1, 16'd1000, 1'b1)));
    dir_tbl.push_back(typed_row(8'd255, 2'd0, '0, '0));            // no change
    dir_tbl.push_back(req_row(8'd1));                               // full pulse count
    dir_tbl.push_back(typed_row(8'd0, 2'd2, mk_seg(1'b0, 16'd0, 1'b0),
                                mk_seg(1'b0, 16'd1000, 1'b1)));
    dir_tbl.push_back(req_row(8'd1));                               // longest run from off
    dir_tbl.push_back(req_row(8'd128));                             // wraps to brighter
    dir_tbl.push_back(cfg_row(REG_ENABLE_DELAY, 16'hFFFF));
    dir_tbl.push_back(cfg_row(REG_PULSE_HALF, 16'hFF00));           // zero half pulse
    dir_tbl.push_back(cfg_row(REG_SETTLE, 16'hFFFF));
    dir_tbl.push_back(cfg_row(REG_SPARE, 16'h1234));
    dir_tbl.push_back(typed_row(8'd0, 2'd2, mk_seg(1'b0, 16'd0, 1'b0),
                                mk_seg(1'b0, 16'd65535, 1'b1)));
    dir_tbl.push_back(typed_row(8'd255, 2'd2, mk_seg(1'b1, 16'd1023, 1'b0),
                                mk_seg(1'b1, 16'd65535, 1'b1)));
    dir_tbl.push_back(req_row(8'd7));                               // small value held at dimmest
    dir_tbl.push_back(req_row(8'd8));
    dir_tbl.push_back(req_row(8'd23));
    dir_tbl.push_back(req_row(8'd24));
    dir_tbl.push_back(req_row(8'd254));
    dir_tbl.push_back(req_row(8'd127));
    dir_tbl.push_back(cfg_row(REG_ENABLE_DELAY, 16'h0000));
    dir_tbl.push_back(cfg_row(REG_PULSE_HALF, 16'h00FF));
    dir_tbl.push_back(cfg_row(REG_SETTLE, 16'h0000));
    dir_tbl.push_back(typed_row(8'd0, 2'd2, mk_seg(1'b0, 16'd0, 1'b0),
                                mk_seg(1'b0, 16'd0, 1'b1)));
    dir_tbl.push_back(req_row(8'd16));
    dir_tbl.push_back(typed_row(8'd0, 2'd2, mk_seg(1'b0, 16'd0, 1'b0),
                                mk_seg(1'b0, 16'd0, 1'b1)));
    dir_tbl.push_back(typed_row(8'd0, 2'd0, '0, '0));
    dir_tbl.push_back(typed_row(8'd255, 2'd2, mk_seg(1'b1, 16'd0, 1'b0),
                                mk_seg(1'b1, 16'd0, 1'b1)));
    dir_tbl.push_back(req_row(8'd136));
    dir_tbl.push_back(req_row(8'd85));
    dir_tbl.push_back(req_row(8'd170));
    dir_tbl.push_back(cfg_row(REG_ENABLE_DELAY, 16'd30));
    dir_tbl.push_back(cfg_row(REG_PULSE_HALF, 16'd1));
    dir_tbl.push_back(cfg_row(REG_SETTLE, 16'd1000));

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg)
        write_reg(dir_tbl[i].idx, dir_tbl[i].val);
      else
        send_request(dir_tbl[i].val[BRIGHT_W-1:0], dir_tbl[i].typed, dir_tbl[i].n_typed,
                     dir_tbl[i].s0, dir_tbl[i].s1);
    end

    // random phases, fresh register settings each; one phase without idling
    for (p = 0; p < RAND_PHASES; p++) begin
      write_reg(REG_ENABLE_DELAY, cfg_pick());
      write_reg(REG_PULSE_HALF, cfg_pick());
      write_reg(REG_SETTLE, cfg_pick());
      write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(65535)));
      calm = (p == 2);
      for (k = 0; k < PHASE_ITEMS; k++)
        send_request(brightness_pick(), 1'b0, 2'd0, '0, '0);
    end
    calm = 1'b0;

    wait_idle();
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
